>>> design/dotrq_pkg.sv
package dotrq_pkg;

   // one stored entry of the deadline chain
   typedef struct packed {
      logic [31:0] deadline;
      logic [15:0] task_id;
   } entry_type;

   // command broadcast to every cell of the chain
   typedef struct packed {
      logic      insert;
      logic      shift;
      entry_type new_entry;
   } cell_ctrl_type;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_TICK = 2'b10
   } state_type;

   // result status codes
   localparam logic [2:0] STATUS_RELEASED  = 3'd0;
   localparam logic [2:0] STATUS_QUEUED    = 3'd1;
   localparam logic [2:0] STATUS_SUBMITTED = 3'd2;
   localparam logic [2:0] STATUS_REFUSED   = 3'd3;
   localparam logic [2:0] STATUS_FULL      = 3'd4;

   // most results one item may give
   localparam logic [4:0] MAX_ROOM = 5'd16;

endpackage

>>> design/dotrq_cell.sv
module dotrq_cell (
   input  logic                    clock,
   input  dotrq_pkg::cell_ctrl_type ctrl,
   input  logic                    occupied,
   input  logic                    prev_after,
   input  dotrq_pkg::entry_type    prev_entry,
   input  dotrq_pkg::entry_type    next_entry,
   output dotrq_pkg::entry_type    entry,
   output logic                    after
);

   dotrq_pkg::entry_type entry_ff;
   dotrq_pkg::entry_type entry_in;

   // new entry belongs behind this one
   assign after = occupied && (entry_ff.deadline <= ctrl.new_entry.deadline);
   assign entry = entry_ff;

   // keep, take the new entry, take from the left or take from the right
   always_comb begin
      entry_in = entry_ff;
      if (ctrl.insert) begin
         if (!prev_after) begin
            entry_in = prev_entry;
         end else if (!after) begin
            entry_in = ctrl.new_entry;
         end
      end else if (ctrl.shift) begin
         entry_in = next_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

>>> design/deadline_ordered_task_release_queue_unit.sv
// deadline ordered task release queue
// req_ channel: one item per handshake, req_command 0 schedules a task,
// 1 is a time tick that releases due tasks from the head of the store.
// rsp_ channel: result items with task id, status, occupancy and a last flag.
// a schedule item gives exactly one result, registered on the clock edge that
// accepts it; the insert runs across the cell chain on that same edge,
// every cell comparing its deadline and shifting right if needed.
// a tick item first moves the sequencer to its tick state and then releases
// one due entry per cycle while the result register is not stalled, through a
// left shift of the chain; a tick that releases nothing gives no result and
// returns to idle, or never leaves idle when the executor is stopped.
// the store is a chain of QUEUE_DEPTH cells; occupancy is a single count.
// req_stall is high while a tick is being worked off and whenever the
// output register holds an item that the receiver stalls; a stalled result
// holds still and the chain waits with it.
// reset clears the count, the sequencer and the output valid; the cells
// hold no reset value and are only read below the count.
module deadline_ordered_task_release_queue_unit #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_command,
   input  logic [31:0] req_current_time,
   input  logic [31:0] req_deadline,
   input  logic [15:0] req_task_id,
   input  logic        req_executor_stopped,
   input  logic [4:0]  req_executor_room,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_out_task_id,
   output logic [2:0]  rsp_status,
   output logic [4:0]  rsp_pending_count,
   output logic        rsp_last
);

   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   dotrq_pkg::state_type     state_ff, state_in;
   logic [CW-1:0]            count_ff, count_in;
   logic [31:0]              now_ff, now_in;
   logic [4:0]               room_ff, room_in;
   logic [4:0]               rel_ff, rel_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [15:0]              rsp_id_ff, rsp_id_in;
   logic [2:0]               rsp_status_ff, rsp_status_in;
   logic [CW-1:0]            rsp_pend_ff, rsp_pend_in;
   logic                     rsp_last_ff, rsp_last_in;

   dotrq_pkg::cell_ctrl_type ctrl;
   dotrq_pkg::entry_type     entry [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0]   after;
   logic [QUEUE_DEPTH-1:0]   occ;

   logic                     out_free;
   logic                     accept;
   logic                     sched_acc;
   logic                     tick_acc;
   logic                     is_due;
   logic                     is_full;
   logic                     head_due;
   logic                     next_due;
   logic                     emit;
   logic                     emit_last;
   logic [4:0]               room_clamped;
   logic [CW+4:0]            pend_ext;

   // handshake
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != dotrq_pkg::ST_IDLE) || !out_free;
   assign accept    = req_valid && !req_stall;
   assign sched_acc = accept && !req_command;
   assign tick_acc  = accept && req_command;

   // schedule decisions
   assign is_due       = req_deadline <= req_current_time;
   assign is_full      = count_ff >= CW'(QUEUE_DEPTH);
   assign room_clamped = (req_executor_room > dotrq_pkg::MAX_ROOM) ?
                         dotrq_pkg::MAX_ROOM : req_executor_room;

   // release decisions at the head of the chain
   assign head_due  = occ[0] && (entry[0].deadline <= now_ff) && (rel_ff < room_ff);
   assign next_due  = occ[1] && (entry[1].deadline <= now_ff);
   assign emit      = (state_ff == dotrq_pkg::ST_TICK) && out_free && head_due;
   assign emit_last = ((rel_ff + 5'd1) == room_ff) || !next_due;

   // chain command
   assign ctrl.insert              = sched_acc && !is_due && !is_full;
   assign ctrl.shift               = emit;
   assign ctrl.new_entry.deadline  = req_deadline;
   assign ctrl.new_entry.task_id   = req_task_id;

   // cell chain
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      dotrq_pkg::entry_type prev_e;
      dotrq_pkg::entry_type next_e;
      logic                 prev_a;

      assign occ[i] = CW'(i) < count_ff;

      if (i == 0) begin : g_head
         assign prev_a = 1'b1;
         assign prev_e = ctrl.new_entry;
      end else begin : g_body
         assign prev_a = after[i-1];
         assign prev_e = entry[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_tail
         assign next_e = entry[i];
      end else begin : g_mid
         assign next_e = entry[i+1];
      end

      dotrq_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .occupied   (occ[i]),
         .prev_after (prev_a),
         .prev_entry (prev_e),
         .next_entry (next_e),
         .entry      (entry[i]),
         .after      (after[i])
      );
   end

   // sequencer, count and result register
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      now_in        = now_ff;
      room_in       = room_ff;
      rel_in        = rel_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_id_in     = rsp_id_ff;
      rsp_status_in = rsp_status_ff;
      rsp_pend_in   = rsp_pend_ff;
      rsp_last_in   = rsp_last_ff;

      unique case (state_ff)
         dotrq_pkg::ST_IDLE: begin
            if (sched_acc) begin
               rsp_valid_in = 1'b1;
               rsp_id_in    = req_task_id;
               rsp_last_in  = 1'b1;
               rsp_pend_in  = count_ff;
               if (is_due) begin
                  rsp_status_in = (req_executor_stopped || (room_clamped == 5'd0)) ?
                                  dotrq_pkg::STATUS_REFUSED :
                                  dotrq_pkg::STATUS_SUBMITTED;
               end else if (is_full) begin
                  rsp_status_in = dotrq_pkg::STATUS_FULL;
               end else begin
                  rsp_status_in = dotrq_pkg::STATUS_QUEUED;
                  count_in      = count_ff + CW'(1);
                  rsp_pend_in   = count_ff + CW'(1);
               end
            end else if (tick_acc && !req_executor_stopped) begin
               state_in = dotrq_pkg::ST_TICK;
               now_in   = req_current_time;
               room_in  = room_clamped;
               rel_in   = 5'd0;
            end
         end
         dotrq_pkg::ST_TICK: begin
            if (out_free) begin
               if (!head_due) begin
                  state_in = dotrq_pkg::ST_IDLE;
               end else begin
                  rsp_valid_in  = 1'b1;
                  rsp_id_in     = entry[0].task_id;
                  rsp_status_in = dotrq_pkg::STATUS_RELEASED;
                  rsp_last_in   = emit_last;
                  count_in      = count_ff - CW'(1);
                  rsp_pend_in   = count_ff - CW'(1);
                  rel_in        = rel_ff + 5'd1;
                  if (emit_last) begin
                     state_in = dotrq_pkg::ST_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = dotrq_pkg::ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dotrq_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      now_ff        <= now_in;
      room_ff       <= room_in;
      rel_ff        <= rel_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pend_ff   <= rsp_pend_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // outputs
   assign pend_ext          = (CW+5)'(rsp_pend_ff);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_task_id   = rsp_id_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_pending_count = pend_ext[4:0];
   assign rsp_last          = rsp_last_ff;

endmodule

>>> sim/dotrq_tb_pkg.sv
package dotrq_tb_pkg;

   // request commands
   typedef enum logic {
      CMD_SCHEDULE = 1'b0,
      CMD_TICK     = 1'b1
   } command_type;

   // one predicted result item
   typedef struct packed {
      logic [15:0] task_id;
      logic [2:0]  status;
      logic [4:0]  pending;
      logic        last;
   } dispatch_type;

endpackage

>>> sim/dotrq_checker.sv
module dotrq_checker #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic        req_command,
   input  logic [31:0] req_current_time,
   input  logic [31:0] req_deadline,
   input  logic [15:0] req_task_id,
   input  logic        req_executor_stopped,
   input  logic [4:0]  req_executor_room,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [15:0] rsp_out_task_id,
   input  logic [2:0]  rsp_status,
   input  logic [4:0]  rsp_pending_count,
   input  logic        rsp_last,
   output int          fail_count,
   output int          dispatch_left
);
   timeunit 1ns;
   timeprecision 1ps;

   // shadow of the deadline chain
   dotrq_pkg::entry_type       shadow_store [QUEUE_DEPTH];
   int                         shadow_count;
   dotrq_tb_pkg::dispatch_type expected_dispatch [$];

   initial begin
      fail_count    = 0;
      dispatch_left = 0;
      shadow_count  = 0;
   end

   // one line per mismatch
   task automatic report_mismatch(input string what, input int got, input int want);
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
      fail_count++;
   endtask

   // work out the result items that one accepted item causes
   task automatic predict_dispatch(input logic cmd, input logic [31:0] now,
                                   input logic [31:0] due_at, input logic [15:0] id,
                                   input logic stopped, input logic [4:0] room_in);
      logic [4:0]                 room;
      int                         pos;
      int                         due;
      int                         n;
      dotrq_tb_pkg::dispatch_type d;
      room = (room_in > dotrq_pkg::MAX_ROOM) ? dotrq_pkg::MAX_ROOM : room_in;
      if (cmd == dotrq_tb_pkg::CMD_SCHEDULE) begin
         d.task_id = id;
         d.last    = 1'b1;
         if (due_at <= now) begin
            // already due: straight to the executor unless it refuses
            d.status = (stopped || room == 5'd0) ? dotrq_pkg::STATUS_REFUSED :
                                                   dotrq_pkg::STATUS_SUBMITTED;
         end else if (shadow_count >= QUEUE_DEPTH) begin
            d.status = dotrq_pkg::STATUS_FULL;
         end else begin
            // insert behind every entry that is due no later
            pos = 0;
            while (pos < shadow_count && shadow_store[pos].deadline <= due_at) pos++;
            for (int i = shadow_count; i > pos; i--) shadow_store[i] = shadow_store[i - 1];
            shadow_store[pos].deadline = due_at;
            shadow_store[pos].task_id  = id;
            shadow_count++;
            d.status = dotrq_pkg::STATUS_QUEUED;
         end
         d.pending = shadow_count[4:0];
         expected_dispatch.push_back(d);
      end else if (!stopped) begin
         // release due entries from the head, bounded by the room
         due = 0;
         while (due < shadow_count && shadow_store[due].deadline <= now) due++;
         n = (due < room) ? due : room;
         for (int k = 0; k < n; k++) begin
            shadow_count--;
            d.task_id = shadow_store[k].task_id;
            d.status  = dotrq_pkg::STATUS_RELEASED;
            d.pending = shadow_count[4:0];
            d.last    = (k == n - 1);
            expected_dispatch.push_back(d);
         end
         for (int i = 0; i < shadow_count; i++) shadow_store[i] = shadow_store[i + n];
      end
   endtask

   // sample at the falling edge, values match the next rising edge
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_dispatch.size() == 0) begin
               report_mismatch("unexpected result, task id", rsp_out_task_id, -1);
            end else begin
               if (rsp_out_task_id !== expected_dispatch[0].task_id)
                  report_mismatch("task id", rsp_out_task_id, expected_dispatch[0].task_id);
               if (rsp_status !== expected_dispatch[0].status)
                  report_mismatch("status", rsp_status, expected_dispatch[0].status);
               if (rsp_pending_count !== expected_dispatch[0].pending)
                  report_mismatch("pending count", rsp_pending_count,
                                  expected_dispatch[0].pending);
               if (rsp_last !== expected_dispatch[0].last)
                  report_mismatch("last", rsp_last, expected_dispatch[0].last);
               void'(expected_dispatch.pop_front());
            end
         end
         if (req_valid && !req_stall) begin
            predict_dispatch(req_command, req_current_time, req_deadline, req_task_id,
                             req_executor_stopped, req_executor_room);
         end
      end
      dispatch_left = expected_dispatch.size();
   end

endmodule

>>> sim/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int QUEUE_DEPTH  = 16;
   localparam int RANDOM_ITEMS = 480;
   localparam int CYCLE_LIMIT  = 400000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_command = 1'b0;
   logic [31:0] req_current_time = '0;
   logic [31:0] req_deadline = '0;
   logic [15:0] req_task_id = '0;
   logic        req_executor_stopped = 1'b0;
   logic [4:0]  req_executor_room = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [15:0] rsp_out_task_id;
   logic [2:0]  rsp_status;
   logic [4:0]  rsp_pending_count;
   logic        rsp_last;

   int          fail_count;
   int          dispatch_left;
   int          cycle_count = 0;
   int          burst_left = 0;
   bit          gaps_on = 1'b1;
   int          stall_seg = 0;
   int          stall_mode = 0;

   deadline_ordered_task_release_queue_unit #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_command(req_command),
      .req_current_time(req_current_time),
      .req_deadline(req_deadline),
      .req_task_id(req_task_id),
      .req_executor_stopped(req_executor_stopped),
      .req_executor_room(req_executor_room),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_out_task_id(rsp_out_task_id),
      .rsp_status(rsp_status),
      .rsp_pending_count(rsp_pending_count),
      .rsp_last(rsp_last)
   );

   dotrq_checker #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) checker_inst (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_command(req_command),
      .req_current_time(req_current_time),
      .req_deadline(req_deadline),
      .req_task_id(req_task_id),
      .req_executor_stopped(req_executor_stopped),
      .req_executor_room(req_executor_room),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_out_task_id(rsp_out_task_id),
      .rsp_status(rsp_status),
      .rsp_pending_count(rsp_pending_count),
      .rsp_last(rsp_last),
      .fail_count(fail_count),
      .dispatch_left(dispatch_left)
   );

   // clock
   initial begin
      forever #5 clock = ~clock;
   end

   // run guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // receiver stall pattern: segments of free flow, light and heavy stalling
   always @(posedge clock) begin
      if (stall_seg == 0) begin
         stall_seg  <= $urandom_range(5, 60);
         stall_mode <= $urandom_range(0, 2);
      end else begin
         stall_seg <= stall_seg - 1;
      end
      unique case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         default: rsp_stall <= ($urandom_range(0, 1) == 0);
      endcase
   end

   // offer one item in a burst, wait for its handshake
   task automatic send_item(input dotrq_tb_pkg::command_type cmd, input logic [31:0] now,
                            input logic [31:0] due_at, input logic [15:0] id,
                            input logic stopped, input logic [4:0] room);
      if (burst_left == 0) begin
         if (gaps_on) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
         end
         burst_left = $urandom_range(1, 16);
         if ($urandom_range(0, 4) == 0) gaps_on = !gaps_on;
      end
      burst_left--;
      req_valid            <= 1'b1;
      req_command          <= cmd;
      req_current_time     <= now;
      req_deadline         <= due_at;
      req_task_id          <= id;
      req_executor_stopped <= stopped;
      req_executor_room    <= room;
      @(negedge clock);
      while (req_stall) @(negedge clock);
      @(posedge clock);
   endtask

   initial begin
      logic [31:0] now;
      logic [31:0] due_at;
      logic [4:0]  room;
      logic        stopped;
      int          pick;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: empty tick, due submissions and refusals
      send_item(dotrq_tb_pkg::CMD_TICK, 32'd0, 32'd0, 16'd0, 1'b0, 5'd16);
      send_item(dotrq_tb_pkg::CMD_SCHEDULE, 32'd0, 32'd0, 16'h0001, 1'b0, 5'd16);
      send_item(dotrq_tb_pkg::CMD_SCHEDULE, 32'd10, 32'd5, 16'h0002, 1'b1, 5'd16);
      send_item(dotrq_tb_pkg::CMD_SCHEDULE, 32'd10, 32'd5, 16'h0003, 1'b0, 5'd0);
      send_item(dotrq_tb_pkg::CMD_SCHEDULE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF,
                1'b0, 5'd31);

      // fill the store, equal deadlines keep arrival order
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         due_at = (i == 0) ? 32'hFFFF_FFFF : 32'(100 + (i % 3) * 10);
         send_item(dotrq_tb_pkg::CMD_SCHEDULE, 32'd0, due_at,
                   (i == 1) ? 16'h0000 : 16'(16'hA000 + i), i[0], i[4:0]);
      end

      // store full, then a due item that bypasses it
      send_item(dotrq_tb_pkg::CMD_SCHEDULE, 32'd0, 32'd200, 16'hBEEF, 1'b0, 5'd16);
      send_item(dotrq_tb_pkg::CMD_SCHEDULE, 32'd0, 32'd0, 16'h5555, 1'b0, 5'd16);

      // ticks: stopped, limited room, no room, room above the limit
      send_item(dotrq_tb_pkg::CMD_TICK, 32'd150, 32'd0, 16'd0, 1'b1, 5'd16);
      send_item(dotrq_tb_pkg::CMD_TICK, 32'd110, 32'd0, 16'd0, 1'b0, 5'd2);
      send_item(dotrq_tb_pkg::CMD_TICK, 32'd150, 32'd0, 16'd0, 1'b0, 5'd0);
      send_item(dotrq_tb_pkg::CMD_TICK, 32'hFFFF_FFFF, 32'd0, 16'd0, 1'b0, 5'd31);

      // random: mostly a steadily advancing clock with near deadlines
      now = $urandom_range(0, 1000);
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 2) now = $urandom();
         else if (pick < 4) now = 32'hFFFF_FFFF - $urandom_range(0, 60);
         stopped = ($urandom_range(0, 9) == 0);
         pick = $urandom_range(0, 99);
         if (pick < 12) room = 5'd0;
         else if (pick < 25) room = 5'($urandom_range(17, 31));
         else room = 5'($urandom_range(1, 16));
         if ($urandom_range(0, 99) < 58) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) due_at = now + $urandom_range(1, 8);
            else if (pick < 65) due_at = now + $urandom_range(1, 60);
            else if (pick < 75) due_at = now;
            else if (pick < 88) due_at = now - $urandom_range(1, 1000);
            else if (pick < 94) due_at = 32'hFFFF_FFFF;
            else due_at = $urandom();
            send_item(dotrq_tb_pkg::CMD_SCHEDULE, now, due_at,
                      16'($urandom_range(0, 65535)), stopped, room);
         end else begin
            now = now + $urandom_range(0, 25);
            send_item(dotrq_tb_pkg::CMD_TICK, now, $urandom(),
                      16'($urandom_range(0, 65535)), stopped, room);
         end
      end
      req_valid <= 1'b0;

      // drain, then wait for any stray result
      while (dispatch_left != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
